// ===== rtl/qcp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the cascaded PID controller.
// No dependencies.
package qcp_pkg;

  localparam logic signed [63:0] ALT_OFFSET = 64'sd3145728;  // 48.0 in Q16.16
  localparam logic signed [31:0] ONE_Q16    = 32'sd65536;
  localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;

  // configuration register indexes
  typedef enum logic [2:0] {
    R_P_RP  = 3'd0,
    R_D_RP  = 3'd1,
    R_P_YAW = 3'd2,
    R_P_VEL = 3'd3,
    R_D_VEL = 3'd4,
    R_P_H   = 3'd5,
    R_I_H   = 3'd6,
    R_D_H   = 3'd7
  } reg_idx_t;

  // derivative jobs for the divider
  typedef enum logic [2:0] {
    D_VF = 3'd0,
    D_VS = 3'd1,
    D_H  = 3'd2,
    D_R  = 3'd3,
    D_P  = 3'd4
  } dop_t;

  // multiplier jobs, issued in this order
  typedef enum logic [3:0] {
    M_VPF = 4'd0,
    M_VDF = 4'd1,
    M_VPS = 4'd2,
    M_VDS = 4'd3,
    M_INT = 4'd4,
    M_IHI = 4'd5,
    M_ILO = 4'd6,
    M_HP  = 4'd7,
    M_HD  = 4'd8,
    M_RP  = 4'd9,
    M_RD  = 4'd10,
    M_PP  = 4'd11,
    M_PD  = 4'd12,
    M_YP  = 4'd13
  } mop_t;

  // accumulator slots
  localparam logic [1:0] ACC_ALT   = 2'd0;
  localparam logic [1:0] ACC_ROLL  = 2'd1;
  localparam logic [1:0] ACC_PITCH = 2'd2;
  localparam logic [1:0] ACC_YAW   = 2'd3;

  typedef struct packed {
    logic signed [31:0] p_rp;
    logic signed [31:0] d_rp;
    logic signed [31:0] p_yaw;
    logic signed [31:0] p_vel;
    logic signed [31:0] d_vel;
    logic signed [31:0] p_h;
    logic signed [31:0] i_h;
    logic signed [31:0] d_h;
  } gains_t;

  typedef struct packed {
    logic               opcode;
    logic [30:0]        step_time;
    logic signed [31:0] meas_roll;
    logic signed [31:0] meas_pitch;
    logic signed [31:0] meas_yaw_rate;
    logic signed [31:0] meas_altitude;
    logic signed [31:0] meas_vel_fwd;
    logic signed [31:0] meas_vel_side;
    logic signed [31:0] target_fwd;
    logic signed [31:0] target_side;
    logic signed [31:0] target_yaw_rate;
    logic signed [31:0] target_altitude;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] motor_1;
    logic signed [31:0] motor_2;
    logic signed [31:0] motor_3;
    logic signed [31:0] motor_4;
    logic signed [31:0] used_pitch_target;
    logic signed [31:0] used_roll_target;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic err;
    logic tgt;
    logic div_start;
    dop_t dop;
    logic mul_issue;
    logic mul_acc;
    mop_t mop;
    logic mix;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic vel_mode;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp1(input logic signed [31:0] e);
    if (e > ONE_Q16) return ONE_Q16;
    if (e < NEG_ONE_Q16) return NEG_ONE_Q16;
    return e;
  endfunction

endpackage

// ===== rtl/qcp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for control-tick words and motor result words.
// Depends on nothing.
interface qcp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [30:0]        step_time;
  logic signed [31:0] meas_roll;
  logic signed [31:0] meas_pitch;
  logic signed [31:0] meas_yaw_rate;
  logic signed [31:0] meas_altitude;
  logic signed [31:0] meas_vel_fwd;
  logic signed [31:0] meas_vel_side;
  logic signed [31:0] target_fwd;
  logic signed [31:0] target_side;
  logic signed [31:0] target_yaw_rate;
  logic signed [31:0] target_altitude;

  modport source (output valid, opcode, step_time, meas_roll, meas_pitch, meas_yaw_rate,
                  meas_altitude, meas_vel_fwd, meas_vel_side, target_fwd, target_side,
                  target_yaw_rate, target_altitude, input ready);
  modport sink (input valid, opcode, step_time, meas_roll, meas_pitch, meas_yaw_rate,
                meas_altitude, meas_vel_fwd, meas_vel_side, target_fwd, target_side,
                target_yaw_rate, target_altitude, output ready);
endinterface

interface qcp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] motor_1;
  logic signed [31:0] motor_2;
  logic signed [31:0] motor_3;
  logic signed [31:0] motor_4;
  logic signed [31:0] used_pitch_target;
  logic signed [31:0] used_roll_target;

  modport source (output valid, motor_1, motor_2, motor_3, motor_4, used_pitch_target,
                  used_roll_target, input ready);
  modport sink (input valid, motor_1, motor_2, motor_3, motor_4, used_pitch_target,
                used_roll_target, output ready);
endinterface

// ===== rtl/qcp_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for the derivative terms: (diff * 65536) / dt, truncated, saturated.
// One quotient bit per cycle, 49 quotient bits. Depends on nothing.
module qcp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] diff,
  input  logic [30:0]        dt,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int unsigned NBITS = 49;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic [48:0] dq_r, dq_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] dt_r, dt_nxt;
  logic [32:0] mag;
  logic [31:0] rem_sh;

  always_comb begin
    mag      = diff[32] ? 33'(-diff) : 33'(diff);
    rem_sh   = {rem_r[30:0], dq_r[48]};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dt_nxt   = dt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(NBITS);
      neg_nxt  = diff[32];
      dq_nxt   = {mag, 16'd0};
      rem_nxt  = '0;
      dt_nxt   = dt;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dt_r}) begin
        rem_nxt = rem_sh - {1'b0, dt_r};
        dq_nxt  = {dq_r[47:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dq_nxt  = {dq_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dt_r  <= dt_nxt;
  end

  // saturate the signed quotient to 32 bits
  always_comb begin
    if (!neg_r) begin
      quot = (dq_r[48:31] != '0) ? 32'sh7fffffff : $signed(dq_r[31:0]);
    end else begin
      if ((dq_r[48:32] != '0) || (dq_r[31] && (dq_r[30:0] != '0))) quot = 32'sh80000000;
      else quot = $signed(32'(-dq_r[31:0]));
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/qcp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: tick register, errors, shared multiplier with accumulators, integrator,
// loop state and motor mixing. Depends on qcp_pkg and qcp_div.
module qcp_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  qcp_pkg::cmd_t     cmd,
  output qcp_pkg::sts_t     sts,
  input  qcp_pkg::in_item_t in_item,
  input  qcp_pkg::gains_t   gains,
  output qcp_pkg::out_item_t out_item
);

  qcp_pkg::in_item_t  it_r;
  logic [30:0]        dt_r;
  logic signed [31:0] ef_r, es_r, eh_r, ye_r, pe_r, re_r, pt_r, rt_r;
  logic signed [31:0] d_r [5];
  logic signed [63:0] acc_r [4];
  logic signed [63:0] prod_r;
  logic signed [47:0] integ_r;
  logic signed [31:0] prev_h_r, prev_p_r, prev_r_r, prev_vf_r, prev_vs_r;
  qcp_pkg::out_item_t out_r;

  logic signed [31:0] div_e, div_p, div_q;
  logic               div_done;
  logic signed [31:0] mul_a, mul_b;
  logic [1:0]         acc_idx;
  logic               acc_sub, acc_floor;
  logic signed [63:0] term, prod_fl;
  logic signed [48:0] integ_sum;
  logic signed [31:0] pt_c, rt_c;
  logic signed [31:0] c_alt, c_roll, c_pitch, c_yaw;

  // derivative operands
  always_comb begin
    case (cmd.dop)
      qcp_pkg::D_VF: begin div_e = ef_r; div_p = prev_vf_r; end
      qcp_pkg::D_VS: begin div_e = es_r; div_p = prev_vs_r; end
      qcp_pkg::D_H:  begin div_e = eh_r; div_p = prev_h_r;  end
      qcp_pkg::D_R:  begin div_e = re_r; div_p = prev_r_r;  end
      qcp_pkg::D_P:  begin div_e = pe_r; div_p = prev_p_r;  end
      default:       begin div_e = eh_r; div_p = prev_h_r;  end
    endcase
  end

  qcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .diff  (33'(div_e) - 33'(div_p)),
    .dt    (dt_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // multiplier operands and where the product goes
  always_comb begin
    acc_sub   = 1'b0;
    acc_floor = 1'b1;
    acc_idx   = qcp_pkg::ACC_ALT;
    case (cmd.mop)
      qcp_pkg::M_VPF: begin
        mul_a = gains.p_vel; mul_b = qcp_pkg::clamp1(ef_r); acc_idx = qcp_pkg::ACC_PITCH;
      end
      qcp_pkg::M_VDF: begin
        mul_a = gains.d_vel; mul_b = d_r[qcp_pkg::D_VF]; acc_idx = qcp_pkg::ACC_PITCH;
      end
      qcp_pkg::M_VPS: begin
        mul_a = gains.p_vel; mul_b = qcp_pkg::clamp1(es_r);
        acc_idx = qcp_pkg::ACC_ROLL; acc_sub = 1'b1;
      end
      qcp_pkg::M_VDS: begin
        mul_a = gains.d_vel; mul_b = d_r[qcp_pkg::D_VS];
        acc_idx = qcp_pkg::ACC_ROLL; acc_sub = 1'b1;
      end
      qcp_pkg::M_INT: begin
        mul_a = eh_r; mul_b = $signed({1'b0, dt_r});
      end
      qcp_pkg::M_IHI: begin
        mul_a = gains.i_h; mul_b = integ_r[47:16]; acc_floor = 1'b0;
      end
      qcp_pkg::M_ILO: begin
        mul_a = gains.i_h; mul_b = $signed({16'd0, integ_r[15:0]});
      end
      qcp_pkg::M_HP: begin
        mul_a = gains.p_h; mul_b = qcp_pkg::clamp1(eh_r);
      end
      qcp_pkg::M_HD: begin
        mul_a = gains.d_h; mul_b = d_r[qcp_pkg::D_H];
      end
      qcp_pkg::M_RP: begin
        mul_a = gains.p_rp; mul_b = qcp_pkg::clamp1(re_r); acc_idx = qcp_pkg::ACC_ROLL;
      end
      qcp_pkg::M_RD: begin
        mul_a = gains.d_rp; mul_b = d_r[qcp_pkg::D_R]; acc_idx = qcp_pkg::ACC_ROLL;
      end
      qcp_pkg::M_PP: begin
        mul_a = gains.p_rp; mul_b = qcp_pkg::clamp1(pe_r);
        acc_idx = qcp_pkg::ACC_PITCH; acc_sub = 1'b1;
      end
      qcp_pkg::M_PD: begin
        mul_a = gains.d_rp; mul_b = d_r[qcp_pkg::D_P];
        acc_idx = qcp_pkg::ACC_PITCH; acc_sub = 1'b1;
      end
      qcp_pkg::M_YP: begin
        mul_a = gains.p_yaw; mul_b = qcp_pkg::clamp1(ye_r); acc_idx = qcp_pkg::ACC_YAW;
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_fl   = prod_r >>> 16;  // arithmetic shift floors
    term      = acc_floor ? prod_fl : prod_r;
    integ_sum = 49'(integ_r) + 49'($signed(prod_fl[47:0]));
  end

  // targets for the attitude loop
  always_comb begin
    if (it_r.opcode) begin
      pt_c = qcp_pkg::sat32(acc_r[qcp_pkg::ACC_PITCH]);
      rt_c = qcp_pkg::sat32(acc_r[qcp_pkg::ACC_ROLL]);
    end else begin
      pt_c = it_r.target_fwd;
      rt_c = it_r.target_side;
    end
  end

  always_comb begin
    c_alt   = qcp_pkg::sat32(acc_r[qcp_pkg::ACC_ALT]);
    c_roll  = qcp_pkg::sat32(acc_r[qcp_pkg::ACC_ROLL]);
    c_pitch = qcp_pkg::sat32(acc_r[qcp_pkg::ACC_PITCH]);
    c_yaw   = qcp_pkg::sat32(acc_r[qcp_pkg::ACC_YAW]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= in_item;
      dt_r <= (in_item.step_time == '0) ? 31'd1 : in_item.step_time;
    end
    if (cmd.err) begin
      ef_r <= qcp_pkg::sat32(64'(it_r.target_fwd) - 64'(it_r.meas_vel_fwd));
      es_r <= qcp_pkg::sat32(64'(it_r.target_side) - 64'(it_r.meas_vel_side));
      eh_r <= qcp_pkg::sat32(64'(it_r.target_altitude) - 64'(it_r.meas_altitude));
      ye_r <= qcp_pkg::sat32(64'(it_r.target_yaw_rate) - 64'(it_r.meas_yaw_rate));
      acc_r[qcp_pkg::ACC_ALT]   <= qcp_pkg::ALT_OFFSET;
      acc_r[qcp_pkg::ACC_ROLL]  <= '0;
      acc_r[qcp_pkg::ACC_PITCH] <= '0;
      acc_r[qcp_pkg::ACC_YAW]   <= '0;
    end
    if (cmd.tgt) begin
      pt_r <= pt_c;
      rt_r <= rt_c;
      pe_r <= qcp_pkg::sat32(64'(pt_c) - 64'(it_r.meas_pitch));
      re_r <= qcp_pkg::sat32(64'(rt_c) - 64'(it_r.meas_roll));
      acc_r[qcp_pkg::ACC_ROLL]  <= '0;
      acc_r[qcp_pkg::ACC_PITCH] <= '0;
    end
    if (div_done) d_r[cmd.dop] <= div_q;
    if (cmd.mul_issue) prod_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd.mul_acc && (cmd.mop != qcp_pkg::M_INT)) begin
      acc_r[acc_idx] <= acc_sub ? (acc_r[acc_idx] - term) : (acc_r[acc_idx] + term);
    end
    if (cmd.mix) begin
      out_r.motor_1 <= qcp_pkg::sat32(64'(c_alt) - 64'(c_roll) + 64'(c_pitch) + 64'(c_yaw));
      out_r.motor_2 <= qcp_pkg::sat32(64'(c_alt) - 64'(c_roll) - 64'(c_pitch) - 64'(c_yaw));
      out_r.motor_3 <= qcp_pkg::sat32(64'(c_alt) + 64'(c_roll) - 64'(c_pitch) + 64'(c_yaw));
      out_r.motor_4 <= qcp_pkg::sat32(64'(c_alt) + 64'(c_roll) + 64'(c_pitch) - 64'(c_yaw));
      out_r.used_pitch_target <= pt_r;
      out_r.used_roll_target  <= rt_r;
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r   <= '0;
      prev_h_r  <= '0;
      prev_p_r  <= '0;
      prev_r_r  <= '0;
      prev_vf_r <= '0;
      prev_vs_r <= '0;
    end else begin
      if (cmd.mul_acc && (cmd.mop == qcp_pkg::M_INT)) begin
        if (integ_sum[48] != integ_sum[47]) integ_r <= integ_sum[48] ? 48'sh800000000000
                                                                     : 48'sh7fffffffffff;
        else integ_r <= integ_sum[47:0];
      end
      if (cmd.mix) begin
        prev_h_r <= eh_r;
        prev_p_r <= pe_r;
        prev_r_r <= re_r;
        if (it_r.opcode) begin
          prev_vf_r <= ef_r;
          prev_vs_r <= es_r;
        end
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.vel_mode = it_r.opcode;
  assign out_item     = out_r;

endmodule

// ===== rtl/qcp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of one control tick: errors, derivative divides, multiply-accumulate
// jobs, mixing, and the result-word valid flag. Depends on qcp_pkg.
module qcp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  qcp_pkg::sts_t sts,
  output qcp_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ERR    = 8'b0000_0010,
    S_DSTART = 8'b0000_0100,
    S_DWAIT  = 8'b0000_1000,
    S_MISSUE = 8'b0001_0000,
    S_MACC   = 8'b0010_0000,
    S_TGT    = 8'b0100_0000,
    S_MIX    = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  qcp_pkg::dop_t   dop_r, dop_nxt;
  qcp_pkg::mop_t   mop_r, mop_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            can_mix;

  assign can_mix = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    dop_nxt       = dop_r;
    mop_nxt       = mop_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.dop       = dop_r;
    cmd.mop       = mop_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        dop_nxt   = sts.vel_mode ? qcp_pkg::D_VF : qcp_pkg::D_H;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          case (dop_r)
            qcp_pkg::D_VF: begin dop_nxt = qcp_pkg::D_VS; state_nxt = S_DSTART; end
            qcp_pkg::D_VS: begin dop_nxt = qcp_pkg::D_H;  state_nxt = S_DSTART; end
            qcp_pkg::D_H: begin
              if (sts.vel_mode) begin
                mop_nxt   = qcp_pkg::M_VPF;
                state_nxt = S_MISSUE;
              end else begin
                state_nxt = S_TGT;
              end
            end
            qcp_pkg::D_R: begin dop_nxt = qcp_pkg::D_P; state_nxt = S_DSTART; end
            default: begin mop_nxt = qcp_pkg::M_INT; state_nxt = S_MISSUE; end
          endcase
        end
      end
      S_MISSUE: begin
        cmd.mul_issue = 1'b1;
        state_nxt     = S_MACC;
      end
      S_MACC: begin
        cmd.mul_acc = 1'b1;
        case (mop_r)
          qcp_pkg::M_VDS: state_nxt = S_TGT;
          qcp_pkg::M_YP:  state_nxt = S_MIX;
          default: begin
            mop_nxt   = qcp_pkg::mop_t'(mop_r + 4'd1);
            state_nxt = S_MISSUE;
          end
        endcase
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        dop_nxt   = qcp_pkg::D_R;
        state_nxt = S_DSTART;
      end
      S_MIX: begin
        // hold here while the previous result word is still unclaimed
        if (can_mix) begin
          cmd.mix       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dop_r       <= qcp_pkg::D_H;
      mop_r       <= qcp_pkg::M_INT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dop_r       <= dop_nxt;
      mop_r       <= mop_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/quadcopter_cascaded_pid.sv =====
`timescale 1ns / 1ps
// Cascaded PID quadcopter controller: one control-tick word in, one motor word out.
// Usage:
//   in_chan  - tick word (opcode, step time, measurements, targets), valid/ready.
//   out_chan - four saturated motor drives plus the pitch/roll targets used.
//   cfg_*    - APB-style port, eight 32-bit Q16.16 gains at byte address 4*i.
// Schedule: one tick runs through a single 32x32 multiplier and a bit-serial
// divider, one derivative divide at a time. Opcode 0 runs three derivative
// divides, opcode 1 five, plus the multiply-accumulate jobs of its loops,
// between accept and result; one tick is in flight at a time.
// Most of the time of a tick is spent in the divider.
// in_chan.ready is high whenever no tick is being worked on, even while the
// last result word still waits to be taken.
// Stall: if out_chan is not taken, the next tick holds in its last step
// and the held result word stays stable until taken.
// Reset (rst_n low, synchronous): gains to their defaults, loop state and
// integrator to zero, no result pending.
module quadcopter_cascaded_pid (
  input  logic        clk,
  input  logic        rst_n,
  qcp_in_if.sink      in_chan,
  qcp_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  qcp_pkg::gains_t    gains_r;
  qcp_pkg::reg_idx_t  ridx;
  qcp_pkg::cmd_t      cmd;
  qcp_pkg::sts_t      sts;
  qcp_pkg::in_item_t  in_item;
  qcp_pkg::out_item_t out_item;

  assign cfg_pready = 1'b1;
  assign ridx       = qcp_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.p_rp  <= 32'sd32768;
      gains_r.d_rp  <= 32'sd6554;
      gains_r.p_yaw <= 32'sd65536;
      gains_r.p_vel <= 32'sd131072;
      gains_r.d_vel <= 32'sd32768;
      gains_r.p_h   <= 32'sd655360;
      gains_r.i_h   <= 32'sd327680;
      gains_r.d_h   <= 32'sd327680;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        qcp_pkg::R_P_RP:  gains_r.p_rp  <= cfg_pwdata;
        qcp_pkg::R_D_RP:  gains_r.d_rp  <= cfg_pwdata;
        qcp_pkg::R_P_YAW: gains_r.p_yaw <= cfg_pwdata;
        qcp_pkg::R_P_VEL: gains_r.p_vel <= cfg_pwdata;
        qcp_pkg::R_D_VEL: gains_r.d_vel <= cfg_pwdata;
        qcp_pkg::R_P_H:   gains_r.p_h   <= cfg_pwdata;
        qcp_pkg::R_I_H:   gains_r.i_h   <= cfg_pwdata;
        qcp_pkg::R_D_H:   gains_r.d_h   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      qcp_pkg::R_P_RP:  cfg_prdata = gains_r.p_rp;
      qcp_pkg::R_D_RP:  cfg_prdata = gains_r.d_rp;
      qcp_pkg::R_P_YAW: cfg_prdata = gains_r.p_yaw;
      qcp_pkg::R_P_VEL: cfg_prdata = gains_r.p_vel;
      qcp_pkg::R_D_VEL: cfg_prdata = gains_r.d_vel;
      qcp_pkg::R_P_H:   cfg_prdata = gains_r.p_h;
      qcp_pkg::R_I_H:   cfg_prdata = gains_r.i_h;
      qcp_pkg::R_D_H:   cfg_prdata = gains_r.d_h;
      default:          cfg_prdata = '0;
    endcase
  end

  always_comb begin
    in_item.opcode          = in_chan.opcode;
    in_item.step_time       = in_chan.step_time;
    in_item.meas_roll       = in_chan.meas_roll;
    in_item.meas_pitch      = in_chan.meas_pitch;
    in_item.meas_yaw_rate   = in_chan.meas_yaw_rate;
    in_item.meas_altitude   = in_chan.meas_altitude;
    in_item.meas_vel_fwd    = in_chan.meas_vel_fwd;
    in_item.meas_vel_side   = in_chan.meas_vel_side;
    in_item.target_fwd      = in_chan.target_fwd;
    in_item.target_side     = in_chan.target_side;
    in_item.target_yaw_rate = in_chan.target_yaw_rate;
    in_item.target_altitude = in_chan.target_altitude;
  end

  qcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qcp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .gains    (gains_r),
    .out_item (out_item)
  );

  assign out_chan.motor_1           = out_item.motor_1;
  assign out_chan.motor_2           = out_item.motor_2;
  assign out_chan.motor_3           = out_item.motor_3;
  assign out_chan.motor_4           = out_item.motor_4;
  assign out_chan.used_pitch_target = out_item.used_pitch_target;
  assign out_chan.used_roll_target  = out_item.used_roll_target;

endmodule

// ===== rtl/qcp_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks of the cascaded PID controller, bound to its top level.
// Depends on quadcopter_cascaded_pid.
module qcp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_motor_1
);

  // a result word is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_motor_1))
    else $error("result word changed while stalled");

  // one tick at a time: accepting a tick closes the input side
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick taken while one is in flight");

  // a tick needs many cycles; no fresh result right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result word appeared too early");

endmodule

bind quadcopter_cascaded_pid qcp_chk u_qcp_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_motor_1 (out_chan.motor_1)
);

// ===== bench/tb_quadcopter_cascaded_pid.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quadcopter_cascaded_pid: random control ticks in, motor words out,
// checked against a cycle-free Q16.16 predictor of the cascaded PID loops.
// Depends on qcp_pkg, qcp_if.sv and the RTL top.
module tb_quadcopter_cascaded_pid;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int LONG_HOLD      = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  qcp_in_if  in_ch ();
  qcp_out_if out_ch ();

  quadcopter_cascaded_pid dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_ch), .out_chan(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  qcp_pkg::in_item_t  tick_q[$];
  qcp_pkg::out_item_t motor_q[$];
  int        errors;
  logic      quiet;      // no idling on either side
  logic      hold_req;   // ask the receiver for one long hold-off

  // predictor state
  int    gain[8];
  int    pv_h, pv_p, pv_r, pv_vf, pv_vs;
  longint h_int;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic int lim1(int e);
    if (e > 65536) return 65536;
    if (e < -65536) return -65536;
    return e;
  endfunction

  function automatic int slope(int e, int prev, longint dt);
    return sat(((longint'(e) - longint'(prev)) * 65536) / dt);
  endfunction

  function automatic longint gmul(int g, int x);
    return fl16(longint'(g) * longint'(x));
  endfunction

  task automatic predict_motors(input qcp_pkg::in_item_t t);
    longint dt, hi, lo, acc;
    int ef, es, df, ds, pt, rt, e, d, pe, re, ye, c_alt, c_roll, c_pitch, c_yaw;
    qcp_pkg::out_item_t r;
    dt = longint'(t.step_time);
    if (dt == 0) dt = 1;
    if (t.opcode) begin
      ef = sat(longint'(t.target_fwd) - t.meas_vel_fwd);
      es = sat(longint'(t.target_side) - t.meas_vel_side);
      df = slope(ef, pv_vf, dt);
      ds = slope(es, pv_vs, dt);
      pt = sat(gmul(gain[qcp_pkg::R_P_VEL], lim1(ef)) + gmul(gain[qcp_pkg::R_D_VEL], df));
      rt = sat(-gmul(gain[qcp_pkg::R_P_VEL], lim1(es)) - gmul(gain[qcp_pkg::R_D_VEL], ds));
      pv_vf = ef;
      pv_vs = es;
    end else begin
      pt = t.target_fwd;
      rt = t.target_side;
    end
    e = sat(longint'(t.target_altitude) - t.meas_altitude);
    d = slope(e, pv_h, dt);
    h_int += fl16(longint'(e) * dt);
    if (h_int > (64'sd1 <<< 47) - 1) h_int = (64'sd1 <<< 47) - 1;
    if (h_int < -(64'sd1 <<< 47)) h_int = -(64'sd1 <<< 47);
    hi = fl16(h_int);
    lo = h_int - hi * 65536;
    acc = longint'(gain[qcp_pkg::R_I_H]) * hi + fl16(longint'(gain[qcp_pkg::R_I_H]) * lo);
    acc += gmul(gain[qcp_pkg::R_P_H], lim1(e)) + gmul(gain[qcp_pkg::R_D_H], d) + 48 * 65536;
    c_alt = sat(acc);
    pv_h = e;
    pe = sat(longint'(pt) - t.meas_pitch);
    re = sat(longint'(rt) - t.meas_roll);
    ye = sat(longint'(t.target_yaw_rate) - t.meas_yaw_rate);
    c_roll = sat(gmul(gain[qcp_pkg::R_P_RP], lim1(re)) +
                 gmul(gain[qcp_pkg::R_D_RP], slope(re, pv_r, dt)));
    c_pitch = sat(-gmul(gain[qcp_pkg::R_P_RP], lim1(pe)) -
                  gmul(gain[qcp_pkg::R_D_RP], slope(pe, pv_p, dt)));
    c_yaw = sat(gmul(gain[qcp_pkg::R_P_YAW], lim1(ye)));
    pv_p = pe;
    pv_r = re;
    r.motor_1 = sat(longint'(c_alt) - c_roll + c_pitch + c_yaw);
    r.motor_2 = sat(longint'(c_alt) - c_roll - c_pitch - c_yaw);
    r.motor_3 = sat(longint'(c_alt) + c_roll - c_pitch + c_yaw);
    r.motor_4 = sat(longint'(c_alt) + c_roll + c_pitch - c_yaw);
    r.used_pitch_target = pt;
    r.used_roll_target = rt;
    motor_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------- driver
  int tx_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_motors(qcp_pkg::in_item_t'{in_ch.opcode,
          in_ch.step_time, in_ch.meas_roll, in_ch.meas_pitch, in_ch.meas_yaw_rate,
          in_ch.meas_altitude, in_ch.meas_vel_fwd, in_ch.meas_vel_side, in_ch.target_fwd,
          in_ch.target_side, in_ch.target_yaw_rate, in_ch.target_altitude});
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0 && !quiet) begin
          tx_gap <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          qcp_pkg::in_item_t t;
          t = tick_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= t.opcode;
          in_ch.step_time <= t.step_time;
          in_ch.meas_roll <= t.meas_roll;
          in_ch.meas_pitch <= t.meas_pitch;
          in_ch.meas_yaw_rate <= t.meas_yaw_rate;
          in_ch.meas_altitude <= t.meas_altitude;
          in_ch.meas_vel_fwd <= t.meas_vel_fwd;
          in_ch.meas_vel_side <= t.meas_vel_side;
          in_ch.target_fwd <= t.target_fwd;
          in_ch.target_side <= t.target_side;
          in_ch.target_yaw_rate <= t.target_yaw_rate;
          in_ch.target_altitude <= t.target_altitude;
          tx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        end else begin
          in_ch.valid <= 1'b0;
          tx_gap <= 0;
        end
      end
    end
  end

  // ---------------- monitor
  int   rx_gap;
  int   hold_left;
  logic hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (motor_q.size() == 0) begin
          report("unexpected motor word", out_ch.motor_1, 32'd0);
        end else begin
          qcp_pkg::out_item_t w;
          w = motor_q.pop_front();
          if (out_ch.motor_1 !== w.motor_1) report("motor_1", out_ch.motor_1, w.motor_1);
          if (out_ch.motor_2 !== w.motor_2) report("motor_2", out_ch.motor_2, w.motor_2);
          if (out_ch.motor_3 !== w.motor_3) report("motor_3", out_ch.motor_3, w.motor_3);
          if (out_ch.motor_4 !== w.motor_4) report("motor_4", out_ch.motor_4, w.motor_4);
          if (out_ch.used_pitch_target !== w.used_pitch_target)
            report("used_pitch_target", out_ch.used_pitch_target, w.used_pitch_target);
          if (out_ch.used_roll_target !== w.used_roll_target)
            report("used_roll_target", out_ch.used_roll_target, w.used_roll_target);
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0 && !quiet) begin
        rx_gap <= rx_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap <= ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
      end
    end
  end

  // ---------------- watchdog
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quadcopter_cascaded_pid verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus helpers
  function automatic int pick_q16();
    int k;
    k = $urandom_range(0, 6);
    case (k)
      0, 1: return $urandom;
      2, 3: return int'($urandom_range(0, 262143)) - 131072;
      4: return int'($urandom_range(0, 4194303)) - 2097152;
      5: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          3: return 65536;
          4: return -65536;
          default: return 65537;
        endcase
      end
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic logic [30:0] pick_dt();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'd1;
      2: return 31'h7fffffff;
      3: return 31'($urandom);
      4, 5: return 31'($urandom_range(1, 131072));
      default: return 31'($urandom_range(300, 1500));
    endcase
  endfunction

  function automatic qcp_pkg::in_item_t random_tick();
    qcp_pkg::in_item_t t;
    t.opcode = 1'($urandom_range(0, 1));
    t.step_time = pick_dt();
    t.meas_roll = pick_q16();
    t.meas_pitch = pick_q16();
    t.meas_yaw_rate = pick_q16();
    t.meas_altitude = pick_q16();
    t.meas_vel_fwd = pick_q16();
    t.meas_vel_side = pick_q16();
    t.target_fwd = pick_q16();
    t.target_side = pick_q16();
    t.target_yaw_rate = pick_q16();
    t.target_altitude = pick_q16();
    return t;
  endfunction

  function automatic qcp_pkg::in_item_t flat_tick(input logic op, input logic [30:0] dt,
                                                  input int m, input int tg);
    return qcp_pkg::in_item_t'{op, dt, m, m, m, m, m, m, tg, tg, tg, tg};
  endfunction

  task automatic write_gain(input qcp_pkg::reg_idx_t idx, input int val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    gain[idx] = val;
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || in_ch.valid || motor_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    qcp_pkg::reg_idx_t ri;
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.step_time = '0;
    in_ch.meas_roll = '0;
    in_ch.meas_pitch = '0;
    in_ch.meas_yaw_rate = '0;
    in_ch.meas_altitude = '0;
    in_ch.meas_vel_fwd = '0;
    in_ch.meas_vel_side = '0;
    in_ch.target_fwd = '0;
    in_ch.target_side = '0;
    in_ch.target_yaw_rate = '0;
    in_ch.target_altitude = '0;
    out_ch.ready = 1'b0;
    gain = '{32768, 6554, 65536, 131072, 32768, 655360, 327680, 327680};
    pv_h = 0; pv_p = 0; pv_r = 0; pv_vf = 0; pv_vs = 0;
    h_int = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset gains, extremes, both opcodes, zero step, clamp edges
    tick_q.push_back(flat_tick(1'b0, 31'd655, 0, 0));
    tick_q.push_back(flat_tick(1'b1, 31'd655, 0, 65536));
    tick_q.push_back(flat_tick(1'b0, 31'd0, 65536, -65536));
    tick_q.push_back(flat_tick(1'b1, 31'd0, -65536, 65537));
    tick_q.push_back(flat_tick(1'b0, 31'd1, 32'sh80000000, 32'sh7fffffff));
    tick_q.push_back(flat_tick(1'b1, 31'd1, 32'sh7fffffff, 32'sh80000000));
    tick_q.push_back(flat_tick(1'b0, 31'h7fffffff, 32'sh80000000, 32'sh7fffffff));
    tick_q.push_back(flat_tick(1'b0, 31'h7fffffff, 32'sh80000000, 32'sh7fffffff));
    tick_q.push_back(flat_tick(1'b1, 31'h7fffffff, 32'sh80000000, 32'sh7fffffff));
    tick_q.push_back(flat_tick(1'b1, 31'h7fffffff, 32'sh7fffffff, 32'sh80000000));
    tick_q.push_back(flat_tick(1'b0, 31'h7fffffff, 32'sh7fffffff, 32'sh80000000));
    tick_q.push_back(flat_tick(1'b1, 31'd65536, 65535, -1));
    tick_q.push_back(flat_tick(1'b0, 31'd65536, -1, 65535));
    tick_q.push_back(flat_tick(1'b1, 31'h55555555, 32'sh55555555, 32'shaaaaaaaa));
    tick_q.push_back(flat_tick(1'b0, 31'h2aaaaaaa, 32'shaaaaaaaa, 32'sh55555555));
    repeat (5) tick_q.push_back(random_tick());
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      for (int k = 0; k < 8; k++) begin
        int v;
        ri = qcp_pkg::reg_idx_t'(k);
        case (ph)
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 0;
          3: v = $urandom;
          4: v = int'($urandom_range(0, 1310720)) - 655360;
          5: v = -65536;
          default: v = int'($urandom_range(0, 262144));
        endcase
        write_gain(ri, v);
      end
      if (ph == 6) quiet = 1'b1;
      for (int n = 0; n < 155; n++) tick_q.push_back(random_tick());
      if (ph == 3) begin
        // hold the receiver off while ticks keep coming
        @(posedge clk);
        hold_req <= 1'b1;
      end
      drain();
    end

    if (motor_q.size() != 0 || errors != 0)
      $display("quadcopter_cascaded_pid verification failed");
    else
      $display("quadcopter_cascaded_pid verification clean");
    $finish;
  end

endmodule
